// ===== sv/bpst_pkg.sv =====
// bpst_pkg: shared types and constants for the battery percent slew tracker
// used by bpst_ctrl, bpst_dp and battery_percent_slew_tracker; no dependencies
`timescale 1ns / 1ps

package bpst_pkg;

    // default converter width
    localparam int ADC_BITS_DEF = 12;

    // level width and fixed percentages
    localparam int         LEVEL_W       = 7;
    localparam logic [6:0] FULL_PERCENT  = 7'd100;
    localparam logic [6:0] START_PERCENT = 7'd50;

    // configuration register indexes
    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] CFG_RAW_MIN = 1'b0;
    localparam logic [0:0] CFG_RAW_MAX = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic need_div;
    } t_status;

endpackage

// ===== sv/bpst_ctrl.sv =====
// bpst_ctrl: sequencing state machine, divider step counter and output valid
// depends on bpst_pkg
`timescale 1ns / 1ps

module bpst_ctrl #(
    parameter int ADC_BITS = bpst_pkg::ADC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  bpst_pkg::t_status i_status,
    output bpst_pkg::t_cmd    o_cmd
);
    import bpst_pkg::*;

    localparam int             DIV_STEPS = ADC_BITS + LEVEL_W;
    localparam int             CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.need_div ? S_DIV : S_FINISH;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall     = 1'b0;
                o_cmd.start = i_valid;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // step counter and output valid
    always_comb begin
        n_cnt = r_cnt;
        if (o_cmd.start) begin
            n_cnt = '0;
        end else if (o_cmd.step) begin
            n_cnt = r_cnt + 1'b1;
        end
        n_out_valid = o_cmd.finish ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    // an in-range sample goes to the divider
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && i_status.need_div) |=> (r_state == S_DIV))
        else $error("in-range sample did not enter divide");

    // divider ends after its fixed step count
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_LAST) |=> (r_state == S_FINISH))
        else $error("divider overran its step count");

    // every finished item shows up as a result
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (o_valid && r_state == S_IDLE))
        else $error("finished item not presented");
`endif

endmodule

// ===== sv/bpst_dp.sv =====
// bpst_dp: calibration registers, target mapping, restoring divider and level
// depends on bpst_pkg
`timescale 1ns / 1ps

module bpst_dp #(
    parameter int ADC_BITS = bpst_pkg::ADC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADC_BITS-1:0]            i_cfg_data,
    input  logic [ADC_BITS-1:0]            i_sample,
    input  bpst_pkg::t_cmd                 i_cmd,
    output bpst_pkg::t_status              o_status,
    output logic [bpst_pkg::LEVEL_W-1:0]   o_level
);
    import bpst_pkg::*;

    localparam int NUM_W = ADC_BITS + LEVEL_W;

    logic [ADC_BITS-1:0] r_raw_min, r_raw_max;
    logic [NUM_W-1:0]    r_num;
    logic [ADC_BITS-1:0] r_den;
    logic [ADC_BITS-1:0] r_rem;
    logic [LEVEL_W-1:0]  r_quo;
    logic [LEVEL_W-1:0]  r_level, n_level;
    logic [LEVEL_W-1:0]  r_out_level;

    logic                below, above, degenerate;
    logic [ADC_BITS-1:0] diff;
    logic [NUM_W-1:0]    diff_ext, num_scaled;
    logic [ADC_BITS:0]   rem_shift;
    logic                fits;
    logic [ADC_BITS:0]   rem_sub;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_min <= '0;
            r_raw_max <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RAW_MIN: r_raw_min <= i_cfg_data;
                CFG_RAW_MAX: r_raw_max <= i_cfg_data;
            endcase
        end
    end

    // sample classification and scaled numerator
    assign below      = i_sample < r_raw_min;
    assign above      = i_sample > r_raw_max;
    assign degenerate = r_raw_max <= r_raw_min;
    assign o_status.need_div = !below && !above && !degenerate;

    assign diff       = i_sample - r_raw_min;
    assign diff_ext   = NUM_W'(diff);
    assign num_scaled = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);

    // one restoring divide step
    assign rem_shift = {r_rem, r_num[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, r_den};
    assign rem_sub   = rem_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_num <= num_scaled;
            r_den <= r_raw_max - r_raw_min;
            r_rem <= '0;
            r_quo <= below ? '0 : FULL_PERCENT;
        end else if (i_cmd.step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= fits ? rem_sub[ADC_BITS-1:0] : rem_shift[ADC_BITS-1:0];
            r_quo <= {r_quo[LEVEL_W-2:0], fits};
        end
    end

    // level moves one percent toward the target; an equal target steps it down
    always_comb begin
        n_level = r_level;
        if (r_quo > r_level) begin
            if (r_level < FULL_PERCENT) begin
                n_level = r_level + 1'b1;
            end
        end else if (r_level != '0) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= START_PERCENT;
        end else if (i_cmd.finish) begin
            r_level <= n_level;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_level <= n_level;
        end
    end

    assign o_level = r_out_level;

`ifndef SYNTHESIS
    // tracked level never leaves the percent range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= FULL_PERCENT)
        else $error("tracked level above full scale");
`endif

endmodule

// ===== sv/battery_percent_slew_tracker.sv =====
// battery_percent_slew_tracker: top level, joins controller and datapath
// depends on bpst_pkg, bpst_ctrl, bpst_dp
//
//   channel   signals                            direction
//   sample    i_valid / o_stall / i_sample       in
//   level     o_valid / i_stall / o_level        out
//   config    i_cfg_we / i_cfg_index / i_cfg_data  in, write only
//
// an in-range sample goes through one load, ADC_BITS + 7 restoring divider
// steps and one level update from transfer to result
// a sample outside the calibration range or a non-positive span skips the divider
// one item at a time; o_stall is low only while no item is in work
// the result register frees the input side; a stalled result holds the finish
// synchronous active-low reset sets level 50, raw_min 0, raw_max all ones
`timescale 1ns / 1ps

module battery_percent_slew_tracker #(
    parameter int ADC_BITS = bpst_pkg::ADC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADC_BITS-1:0]            i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ADC_BITS-1:0]            i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bpst_pkg::LEVEL_W-1:0]   o_level
);
    import bpst_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencing
    bpst_ctrl #(
        .ADC_BITS (ADC_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic and state
    bpst_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_level     (o_level)
    );

endmodule
